// File: design/sfcr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfcr_pkg
// Shared codes, constants and types of the SPI flash command responder.
// ----------------------------------------------------------------------------
package sfcr_pkg;

  localparam logic [1:0] KIND_SELECT = 2'd0;
  localparam logic [1:0] KIND_SEND   = 2'd1;
  localparam logic [1:0] KIND_RECV   = 2'd2;

  localparam logic [7:0] CMD_READ_DATA = 8'h03;
  localparam logic [7:0] CMD_JEDEC_ID  = 8'h9f;
  localparam logic [7:0] CMD_UNIQUE_ID = 8'h4b;

  localparam logic [7:0]  MANUFACTURER_ID_RST = 8'hef;
  localparam logic [15:0] DEVICE_ID_RST       = 16'h4018;
  localparam logic [63:0] UNIQUE_ID_RST       = 64'h1234_5678_9abc_def0;

  localparam logic [1:0] REG_MANUFACTURER_ID = 2'd0;
  localparam logic [1:0] REG_DEVICE_ID       = 2'd1;
  localparam logic [1:0] REG_UNIQUE_ID       = 2'd2;

  localparam logic [2:0] SENT_CMD_ONLY = 3'd1;
  localparam logic [2:0] SENT_FULL     = 3'd4;
  localparam logic [3:0] RECV_MAX      = 4'd15;
  localparam logic [3:0] RECV_ADDR     = 4'd4;
  localparam logic [3:0] RECV_UID_LO   = 4'd5;
  localparam logic [3:0] RECV_UID_HI   = 4'd12;

  typedef struct packed {
    logic        selected;
    logic [2:0]  sent_count;
    logic [3:0]  received_count;
    logic [7:0]  command_code;
    logic [23:0] address_bytes;
    logic [23:0] read_pointer;
  } sfcr_state_t;

  typedef struct packed {
    logic [7:0]  manufacturer_id;
    logic [15:0] device_id;
    logic [63:0] unique_id;
  } sfcr_cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        select_level;
    logic [7:0]  send_byte;
    logic [31:0] mem_word;
  } sfcr_item_t;

endpackage
`default_nettype wire

// File: design/spi_flash_command_responder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spi_flash_command_responder_unit
// Flash-side SPI responder for read data, JEDEC ID and unique ID commands.
// ----------------------------------------------------------------------------
// The result of a transfer is in the output register on the edge that accepts
// it and is offered from the next cycle on.
// Throughput: one item per cycle while the output is not held, set by the single state update path.
// The input side stays ready while the output register is empty or drained.
// Reset clears bus state and loads the identification registers defaults.
module spi_flash_command_responder_unit import sfcr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [0] select_level, [8:1] send_byte, [40:9] mem_word, [47:41] zero
  input  wire logic [47:0] s_axis_tdata,
  // [1:0] kind
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] reply_byte, [31:8] read_address
  output logic [31:0]      m_axis_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  sfcr_state_t state_q, state_d;
  sfcr_cfg_t   cfg_q;
  sfcr_item_t  item;
  logic [7:0]  reply;
  logic        in_fire;
  logic        cfg_we;
  logic [1:0]  reg_idx;
  logic        m_valid_q;
  logic [31:0] m_data_q;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx)
      REG_MANUFACTURER_ID: prdata = {56'd0, cfg_q.manufacturer_id};
      REG_DEVICE_ID:       prdata = {48'd0, cfg_q.device_id};
      REG_UNIQUE_ID:       prdata = cfg_q.unique_id;
      default:             prdata = 64'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.manufacturer_id <= MANUFACTURER_ID_RST;
      cfg_q.device_id       <= DEVICE_ID_RST;
      cfg_q.unique_id       <= UNIQUE_ID_RST;
    end else if (cfg_we) begin
      case (reg_idx)
        REG_MANUFACTURER_ID: cfg_q.manufacturer_id <= pwdata[7:0];
        REG_DEVICE_ID:       cfg_q.device_id       <= pwdata[15:0];
        REG_UNIQUE_ID:       cfg_q.unique_id       <= pwdata;
        default:             cfg_q                 <= cfg_q;
      endcase
    end
  end

  assign item.kind         = s_axis_tuser;
  assign item.select_level = s_axis_tdata[0];
  assign item.send_byte    = s_axis_tdata[8:1];
  assign item.mem_word     = s_axis_tdata[40:9];

  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  sfcr_step u_step (
    .state_i (state_q),
    .cfg_i   (cfg_q),
    .item_i  (item),
    .state_o (state_d),
    .reply_o (reply)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        state_q   <= state_d;
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      m_data_q <= {state_d.read_pointer, reply};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  a_select_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && s_axis_tuser == KIND_SELECT && s_axis_tdata[0] && !state_q.selected
    |=> state_q.selected && state_q.sent_count == 3'd0 && state_q.received_count == 4'd0)
    else $error("select did not clear counters");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> $stable(state_q))
    else $error("state changed without a transfer");

  a_send_deselected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && s_axis_tuser == KIND_SEND && !state_q.selected |=> $stable(state_q))
    else $error("send while deselected changed state");

  a_reply_only_recv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && s_axis_tuser != KIND_RECV |=> m_axis_tdata[7:0] == 8'd0)
    else $error("nonzero reply for a non-receive transfer");

  a_sent_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q.sent_count <= SENT_FULL)
    else $error("sent count out of range");

endmodule
`default_nettype wire

// File: design/sfcr_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfcr_step
// Next-state and reply logic for one bus event of the flash responder.
// ----------------------------------------------------------------------------
module sfcr_step import sfcr_pkg::*; (
  input  sfcr_state_t state_i,
  input  sfcr_cfg_t   cfg_i,
  input  sfcr_item_t  item_i,
  output sfcr_state_t state_o,
  output logic [7:0]  reply_o
);

  logic        active;
  logic [23:0] ptr;
  logic [2:0]  uid_idx;
  logic [7:0]  data_byte;

  assign active  = state_i.selected && (state_i.sent_count != 3'd0);
  assign ptr     = (state_i.received_count == RECV_ADDR) ? state_i.address_bytes
                                                         : state_i.read_pointer;
  assign uid_idx = 3'(RECV_UID_HI - state_i.received_count);

  always_comb begin
    case (ptr[1:0])
      2'd0:    data_byte = item_i.mem_word[7:0];
      2'd1:    data_byte = item_i.mem_word[15:8];
      2'd2:    data_byte = item_i.mem_word[23:16];
      default: data_byte = item_i.mem_word[31:24];
    endcase
  end

  always_comb begin
    state_o = state_i;
    reply_o = 8'd0;
    case (item_i.kind)
      KIND_SELECT: begin
        if (item_i.select_level != state_i.selected) begin
          state_o.selected = item_i.select_level;
          if (item_i.select_level) begin
            state_o.sent_count     = 3'd0;
            state_o.received_count = 4'd0;
          end
        end
      end
      KIND_SEND: begin
        if (state_i.selected) begin
          if (state_i.sent_count == 3'd0) begin
            state_o.command_code = item_i.send_byte;
            state_o.sent_count   = SENT_CMD_ONLY;
          end else if (state_i.command_code == CMD_READ_DATA &&
                       state_i.sent_count < SENT_FULL) begin
            case (state_i.sent_count)
              3'd1:    state_o.address_bytes[23:16] = item_i.send_byte;
              3'd2:    state_o.address_bytes[15:8]  = item_i.send_byte;
              default: state_o.address_bytes[7:0]   = item_i.send_byte;
            endcase
            state_o.sent_count = 3'(state_i.sent_count + 3'd1);
          end
        end
      end
      KIND_RECV: begin
        if (active) begin
          case (state_i.command_code)
            CMD_JEDEC_ID: begin
              case (state_i.received_count)
                4'd1:    reply_o = cfg_i.manufacturer_id;
                4'd2:    reply_o = cfg_i.device_id[15:8];
                4'd3:    reply_o = cfg_i.device_id[7:0];
                default: reply_o = 8'd0;
              endcase
            end
            CMD_UNIQUE_ID: begin
              if (state_i.received_count >= RECV_UID_LO &&
                  state_i.received_count <= RECV_UID_HI) begin
                reply_o = cfg_i.unique_id[{uid_idx, 3'b000} +: 8];
              end
            end
            CMD_READ_DATA: begin
              if (state_i.received_count >= RECV_ADDR) begin
                reply_o              = data_byte;
                state_o.read_pointer = 24'(ptr + 24'd1);
              end
            end
            default: reply_o = 8'd0;
          endcase
          if (state_i.received_count < RECV_MAX) begin
            state_o.received_count = 4'(state_i.received_count + 4'd1);
          end
        end
      end
      default: reply_o = 8'd0;
    endcase
  end

endmodule
`default_nettype wire
